[rtl/soc_pkg.sv]
// shared constants and controller/datapath interface types
// for the sorted occurrence counter; no dependencies
package soc_pkg;

  localparam int STORE_DEPTH   = 1024;
  localparam int ELEMENT_WIDTH = 32;
  localparam int IDX_W         = $clog2(STORE_DEPTH);
  localparam int CNT_W         = IDX_W + 1;
  localparam int POS_W         = IDX_W + 2;
  localparam int KIND_W        = 2;

  localparam logic [KIND_W-1:0] KIND_APPEND = 2'd0;
  localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

  typedef struct packed {
    logic do_append;
    logic do_clear;
    logic do_query;
    logic init;
    logic probe;
    logic toward_left;
    logic save_first;
    logic load_result;
  } soc_cmd_t;

  typedef struct packed {
    logic more;
  } soc_status_t;

endpackage

[rtl/soc_ctrl.sv]
// controller state machine for the sorted occurrence counter
// depends on soc_pkg; drives soc_dp through soc_cmd_t
module soc_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [soc_pkg::KIND_W-1:0] kind,
  output logic                       out_valid,
  input  logic                       out_ready,
  output soc_pkg::soc_cmd_t          cmd,
  input  soc_pkg::soc_status_t       status
);

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_INIT_F  = 3'd1;
  localparam logic [2:0] ST_PROBE_F = 3'd2;
  localparam logic [2:0] ST_INIT_L  = 3'd3;
  localparam logic [2:0] ST_PROBE_L = 3'd4;
  localparam logic [2:0] ST_DONE    = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_valid_next;
  logic       in_xfer;

  assign in_ready = (state == ST_IDLE);
  assign in_xfer  = in_valid && in_ready;

  always_comb begin
    cmd            = '0;
    state_next     = state;
    out_valid_next = out_valid && !out_ready;
    case (state)
      ST_IDLE: begin
        if (in_xfer) begin
          cmd.do_append = (kind == soc_pkg::KIND_APPEND);
          cmd.do_clear  = (kind == soc_pkg::KIND_CLEAR);
          cmd.do_query  = (kind == soc_pkg::KIND_QUERY);
          if (kind == soc_pkg::KIND_QUERY) state_next = ST_INIT_F;
        end
      end
      ST_INIT_F: begin
        cmd.init        = 1'b1;
        cmd.toward_left = 1'b1;
        state_next      = status.more ? ST_PROBE_F : ST_INIT_L;
      end
      ST_PROBE_F: begin
        cmd.probe       = 1'b1;
        cmd.toward_left = 1'b1;
        if (!status.more) state_next = ST_INIT_L;
      end
      ST_INIT_L: begin
        cmd.init       = 1'b1;
        cmd.save_first = 1'b1;
        state_next     = status.more ? ST_PROBE_L : ST_DONE;
      end
      ST_PROBE_L: begin
        cmd.probe = 1'b1;
        if (!status.more) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.load_result = 1'b1;
          out_valid_next  = 1'b1;
          state_next      = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

[rtl/soc_dp.sv]
// datapath: element memory, fill count, search bounds and result registers
// depends on soc_pkg; commanded by soc_ctrl
module soc_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  soc_pkg::soc_cmd_t                   cmd,
  output soc_pkg::soc_status_t                status,
  input  logic signed [soc_pkg::ELEMENT_WIDTH-1:0] value,
  output logic                                found,
  output logic [soc_pkg::IDX_W-1:0]           first_index,
  output logic [soc_pkg::IDX_W-1:0]           last_index,
  output logic [soc_pkg::CNT_W-1:0]           occurrences
);

  localparam int IW = soc_pkg::IDX_W;
  localparam int CW = soc_pkg::CNT_W;
  localparam int PW = soc_pkg::POS_W;
  localparam int EW = soc_pkg::ELEMENT_WIDTH;

  logic [EW-1:0] mem [soc_pkg::STORE_DEPTH];

  logic [CW-1:0]        count;
  logic signed [EW-1:0] target;
  logic signed [EW-1:0] rd_data;
  logic signed [PW-1:0] lo, hi, lo_next, hi_next;
  logic [IW-1:0]        mid_q;
  logic [IW-1:0]        mid_next;
  logic signed [PW:0]   mid_sum;
  logic [IW-1:0]        hit, hit_next;
  logic                 hit_ok, hit_ok_next;
  logic [IW-1:0]        first_hit;
  logic                 first_ok;
  logic signed [PW-1:0] mid_ext;

  assign mid_ext = $signed({2'b00, mid_q});

  // bound update from the probe that just returned
  always_comb begin
    lo_next     = lo;
    hi_next     = hi;
    hit_next    = hit;
    hit_ok_next = hit_ok;
    if (cmd.init) begin
      lo_next     = '0;
      hi_next     = $signed({1'b0, count}) - PW'(1);
      hit_ok_next = 1'b0;
    end else if (cmd.probe) begin
      if (rd_data == target) begin
        hit_next    = mid_q;
        hit_ok_next = 1'b1;
        if (cmd.toward_left) hi_next = mid_ext - PW'(1);
        else                 lo_next = mid_ext + PW'(1);
      end else if (rd_data < target) begin
        lo_next = mid_ext + PW'(1);
      end else begin
        hi_next = mid_ext - PW'(1);
      end
    end
  end

  assign mid_sum     = (PW + 1)'(lo_next) + (PW + 1)'(hi_next);
  assign mid_next    = mid_sum[IW:1];
  assign status.more = (lo_next <= hi_next);

  always_ff @(posedge clk) begin
    if (cmd.do_append && (count < CW'(soc_pkg::STORE_DEPTH))) begin
      mem[count[IW-1:0]] <= value;
    end
    rd_data <= mem[mid_next];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.do_clear) begin
      count <= '0;
    end else if (cmd.do_append && (count < CW'(soc_pkg::STORE_DEPTH))) begin
      count <= count + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.do_query) target <= value;
    lo     <= lo_next;
    hi     <= hi_next;
    mid_q  <= mid_next;
    hit    <= hit_next;
    hit_ok <= hit_ok_next;
    if (cmd.save_first) begin
      first_hit <= hit;
      first_ok  <= hit_ok;
    end
    if (cmd.load_result) begin
      if (first_ok && hit_ok) begin
        found       <= 1'b1;
        first_index <= first_hit;
        last_index  <= hit;
        occurrences <= (hit >= first_hit) ? ({1'b0, hit} - {1'b0, first_hit} + CW'(1))
                                          : '0;
      end else begin
        found       <= 1'b0;
        first_index <= '0;
        last_index  <= '0;
        occurrences <= '0;
      end
    end
  end

endmodule

[rtl/sorted_occurrence_counter_unit.sv]
// sorted occurrence counter: append / query / clear over a sorted element memory
// append, clear and unused kinds are done in the accept cycle; a query holds the unit through the
// accept cycle, two binary searches of at most 11 probes, one per cycle on the single read port,
// each search with its own setup state, and the result state; throughput: one item at a time;
// a stalled result holds the unit in the result state; reset empties
// the store (fill count to zero); depends on soc_pkg, soc_ctrl, soc_dp
module sorted_occurrence_counter_unit (
  input  logic                                     clk,
  input  logic                                     rst,
  // input item channel
  input  logic                                     in_valid,
  output logic                                     in_ready,
  input  logic [soc_pkg::KIND_W-1:0]               kind,
  input  logic signed [soc_pkg::ELEMENT_WIDTH-1:0] value,
  // result channel, one transfer per query
  output logic                                     out_valid,
  input  logic                                     out_ready,
  output logic                                     found,
  output logic [soc_pkg::IDX_W-1:0]                first_index,
  output logic [soc_pkg::IDX_W-1:0]                last_index,
  output logic [soc_pkg::CNT_W-1:0]                occurrences
);

  soc_pkg::soc_cmd_t    cmd;
  soc_pkg::soc_status_t status;

  // sequencing: idle, first-occurrence search, last-occurrence search, result
  soc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .kind      (kind),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .status    (status)
  );

  // memory, bounds, comparator and the result register
  soc_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .value       (value),
    .found       (found),
    .first_index (first_index),
    .last_index  (last_index),
    .occurrences (occurrences)
  );

endmodule
